/* design/rotary_encoder_panel_macros.svh */
// assertion helpers for the encoder panel, sampled on clk, off during reset
`ifndef ROTARY_ENCODER_PANEL_MACROS_SVH
`define ROTARY_ENCODER_PANEL_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define REP_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define REP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/rep_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package rep_pkg;

  // op codes
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_SET   = 2'd1;
  localparam logic [1:0] OP_FLAG  = 2'd2;

  // step codes
  localparam logic [1:0] STEP_NONE = 2'd0;
  localparam logic [1:0] STEP_UP   = 2'd1;
  localparam logic [1:0] STEP_DOWN = 2'd2;

  // register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCKOUT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd1;
  localparam int unsigned CFG_DATA_W = 10;

  localparam logic [7:0] LOCKOUT_RST  = 8'd2;
  localparam logic [9:0] DEBOUNCE_RST = 10'd50;
  localparam logic [7:0] TICKS_MAX    = 8'hFF;

  typedef struct packed {
    logic [1:0]         op;
    logic               enc_clock;
    logic               enc_data;
    logic               key_level;
    logic signed [31:0] load_value;
  } rep_in_t;

  typedef struct packed {
    logic signed [31:0] position;
    logic [3:0]         display_nibble;
    logic               cw_lamp;
    logic               ccw_lamp;
    logic               flag_lamp;
    logic [1:0]         step_taken;
  } rep_out_t;

  typedef struct packed {
    logic [7:0] lockout_ticks;
    logic [9:0] debounce_ticks;
  } rep_cfg_t;

endpackage

`default_nettype wire

/* design/rep_cfg_regs.sv */
`timescale 1ns / 1ps
`default_nettype none

module rep_cfg_regs
  import rep_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  wr_en,
  input  wire logic [CFG_IDX_W-1:0]  wr_index,
  input  wire logic [CFG_DATA_W-1:0] wr_data,
  output rep_cfg_t                   cfg
);

  logic [7:0] lockout_r;
  logic [9:0] debounce_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lockout_r  <= LOCKOUT_RST;
      debounce_r <= DEBOUNCE_RST;
    end else if (wr_en) begin
      case (wr_index)
        CFG_LOCKOUT:  lockout_r  <= wr_data[7:0];
        CFG_DEBOUNCE: debounce_r <= wr_data[9:0];
        default: ;
      endcase
    end
  end

  assign cfg.lockout_ticks  = lockout_r;
  assign cfg.debounce_ticks = debounce_r;

endmodule

`default_nettype wire

/* design/rep_step_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

module rep_step_unit
  import rep_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     fire,
  input  wire rep_in_t  item,
  input  wire rep_cfg_t cfg,
  output rep_out_t      result
);

  logic        prev_clk_r, prev_clk_nxt;
  logic        acc_clk_r, acc_clk_nxt;
  logic [7:0]  tsa_r, tsa_nxt;
  logic [31:0] count_r, count_nxt;
  logic        cw_r, cw_nxt;
  logic        ccw_r, ccw_nxt;
  logic        flag_r, flag_nxt;
  logic        prev_key_r, prev_key_nxt;
  logic        busy_r, busy_nxt;
  logic [9:0]  left_r, left_nxt;

  logic [7:0]  elapsed;
  logic        enc_edge;
  logic [9:0]  left_dec;
  logic        busy_mid;
  logic [1:0]  step;

  assign elapsed  = (tsa_r == TICKS_MAX) ? TICKS_MAX : tsa_r + 8'd1;
  assign enc_edge = item.enc_clock != prev_clk_r;
  assign left_dec = left_r - 10'd1;

  always_comb begin
    prev_clk_nxt = prev_clk_r;
    acc_clk_nxt  = acc_clk_r;
    tsa_nxt      = tsa_r;
    count_nxt    = count_r;
    cw_nxt       = cw_r;
    ccw_nxt      = ccw_r;
    flag_nxt     = flag_r;
    prev_key_nxt = prev_key_r;
    busy_nxt     = busy_r;
    left_nxt     = left_r;
    busy_mid     = busy_r;
    step         = STEP_NONE;
    case (item.op)
      OP_TICK: begin
        prev_clk_nxt = item.enc_clock;
        if (enc_edge && (elapsed > cfg.lockout_ticks)) begin
          // only a falling accepted level change steps the count
          if ((item.enc_clock != acc_clk_r) && !item.enc_clock) begin
            if (item.enc_data) begin
              count_nxt = count_r + 32'd1;
              cw_nxt    = 1'b1;
              ccw_nxt   = 1'b0;
              step      = STEP_UP;
            end else begin
              count_nxt = count_r - 32'd1;
              cw_nxt    = 1'b0;
              ccw_nxt   = 1'b1;
              step      = STEP_DOWN;
            end
          end
          acc_clk_nxt = item.enc_clock;
          tsa_nxt     = 8'd0;
        end else begin
          tsa_nxt = elapsed;
        end
        // key debounce: count down first, then a new press may start a wait
        if (busy_r) begin
          left_nxt = left_dec;
          if (left_dec == 10'd0) begin
            if (!item.key_level) begin
              flag_nxt = ~flag_r;
            end
            busy_mid = 1'b0;
          end
        end
        busy_nxt = busy_mid;
        if (!busy_mid && prev_key_r && !item.key_level) begin
          busy_nxt = 1'b1;
          left_nxt = (cfg.debounce_ticks == 10'd0) ? 10'd1 : cfg.debounce_ticks;
        end
        prev_key_nxt = item.key_level;
      end
      OP_SET:  count_nxt = item.load_value;
      OP_FLAG: flag_nxt  = ~flag_r;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_clk_r <= 1'b1;
      acc_clk_r  <= 1'b1;
      tsa_r      <= TICKS_MAX;
      count_r    <= 32'd0;
      cw_r       <= 1'b0;
      ccw_r      <= 1'b0;
      flag_r     <= 1'b0;
      prev_key_r <= 1'b1;
      busy_r     <= 1'b0;
      left_r     <= 10'd0;
    end else if (fire) begin
      prev_clk_r <= prev_clk_nxt;
      acc_clk_r  <= acc_clk_nxt;
      tsa_r      <= tsa_nxt;
      count_r    <= count_nxt;
      cw_r       <= cw_nxt;
      ccw_r      <= ccw_nxt;
      flag_r     <= flag_nxt;
      prev_key_r <= prev_key_nxt;
      busy_r     <= busy_nxt;
      left_r     <= left_nxt;
    end
  end

  assign result.position       = $signed(count_nxt);
  assign result.display_nibble = count_nxt[3:0];
  assign result.cw_lamp        = cw_nxt;
  assign result.ccw_lamp       = ccw_nxt;
  assign result.flag_lamp      = flag_nxt;
  assign result.step_taken     = step;

endmodule

`default_nettype wire

/* design/rotary_encoder_panel.sv */
// channel | ports                               | direction | word
// --------+-------------------------------------+-----------+------------------------
// input   | in_valid in_ready in_data           | in        | rep_in_t: op, pins, count
// result  | out_valid out_ready out_data        | out       | rep_out_t: count, lamps
// config  | cfg_valid cfg_ready cfg_index/data  | in        | index 0 lockout, 1 debounce
//
// one word per cycle sustained while out_ready is high; a taken word passes through
// the input register, then the single-pass step logic into the result register
// rst_n is synchronous, active low; config ready is always high
// a stalled result lets one more word wait in the input register, then in_ready drops
// config is to be written only while the block is idle; the block does not enforce it
`timescale 1ns / 1ps
`default_nettype none
`include "rotary_encoder_panel_macros.svh"

module rotary_encoder_panel
  import rep_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // input channel
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire rep_in_t               in_data,
  // result channel
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output rep_out_t                   out_data,
  // configuration write channel
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  // input register: holds one word until the step logic consumes it
  logic     hold_v_r;
  rep_in_t  hold_r;
  // result register
  logic     res_v_r;
  rep_out_t res_r;

  rep_cfg_t cfg;
  rep_out_t step_res;
  logic     adv;

  // the held word moves on whenever the result slot is empty or being drained
  assign adv       = hold_v_r && (!res_v_r || out_ready);
  assign in_ready  = !hold_v_r || adv;
  assign cfg_ready = 1'b1;

  rep_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // encoder / debounce state and its next-value logic
  rep_step_unit u_step (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (adv),
    .item   (hold_r),
    .cfg    (cfg),
    .result (step_res)
  );

  // input register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      hold_v_r <= 1'b1;
    end else if (adv) begin
      hold_v_r <= 1'b0;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_r <= in_data;
    end
  end

  // result register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_v_r <= 1'b0;
    end else if (adv) begin
      res_v_r <= 1'b1;
    end else if (out_ready) begin
      res_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= step_res;
    end
  end

  assign out_valid = res_v_r;
  assign out_data  = res_r;

  // checks on the datapath and the two-stage hand-off
  `REP_ASSERT_SAME(a_nibble_low_bits, res_v_r, res_r.display_nibble == res_r.position[3:0], "display nibble does not match position")
  `REP_ASSERT_SAME(a_up_lamps, res_v_r && (res_r.step_taken == STEP_UP), res_r.cw_lamp && !res_r.ccw_lamp, "up step without clockwise lamp")
  `REP_ASSERT_SAME(a_down_lamps, res_v_r && (res_r.step_taken == STEP_DOWN), res_r.ccw_lamp && !res_r.cw_lamp, "down step without counter-clockwise lamp")
  `REP_ASSERT_NEXT(a_adv_fills_result, adv, res_v_r, "consumed word left no result")
  `REP_ASSERT_NEXT(a_accept_fills_hold, in_valid && in_ready, hold_v_r, "accepted word not held")

endmodule

`default_nettype wire

/* bench/tb.sv */
`timescale 1ns / 1ps

module tb;
  import rep_pkg::*;

  // op 3 has no name in the package: the block must treat it as a no-op
  localparam logic [1:0]           OP_SPARE      = 2'd3;
  // index 3 selects no register
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE     = 2'd3;
  localparam int unsigned          CYCLE_LIMIT   = 400000;
  // quiet spell after every pending result has drained
  localparam int unsigned          SETTLE_CYCLES = 8;

  // every block input starts at a known level
  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  rep_in_t               in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  rep_out_t              out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // random idle bursts on both channels while set
  bit pacing_on = 1'b1;

  rotary_encoder_panel DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 4 ns period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // panel predictor: own copy of registers and state, starts at reset values
  // ---------------------------------------------------------------------------
  logic [7:0]  cfg_lockout   = LOCKOUT_RST;
  logic [9:0]  cfg_debounce  = DEBOUNCE_RST;
  logic        clk_level     = 1'b1;      // last sampled encoder clock
  logic        clk_taken     = 1'b1;      // level of the last accepted edge
  logic [7:0]  since_taken   = TICKS_MAX; // ticks since that edge, saturating
  logic [31:0] count_now     = '0;
  logic        cw_now        = 1'b0;
  logic        ccw_now       = 1'b0;
  logic        flag_now      = 1'b0;
  logic        key_prev      = 1'b1;
  logic        key_wait      = 1'b0;      // debounce wait running
  logic [9:0]  key_wait_left = '0;

  int unsigned words_taken, results_seen, mismatches;
  int unsigned up_steps, down_steps, key_toggles;

  rep_out_t predicted_panel[$];

  // applies one word to the predictor and returns the panel it should show
  function automatic rep_out_t panel_advance(input rep_in_t w);
    rep_out_t   r;
    logic [7:0] elapsed;
    logic [1:0] step;
    step = STEP_NONE;
    case (w.op)
      OP_TICK: begin
        // elapsed count advances before the lockout compare
        elapsed = (since_taken == TICKS_MAX) ? TICKS_MAX : since_taken + 8'd1;
        if (w.enc_clock != clk_level && elapsed > cfg_lockout) begin
          // only a fresh fall of the accepted level moves the count
          if (w.enc_clock != clk_taken && !w.enc_clock) begin
            if (w.enc_data) begin
              count_now = count_now + 32'd1;
              cw_now    = 1'b1;
              ccw_now   = 1'b0;
              step      = STEP_UP;
              up_steps++;
            end else begin
              count_now = count_now - 32'd1;
              cw_now    = 1'b0;
              ccw_now   = 1'b1;
              step      = STEP_DOWN;
              down_steps++;
            end
          end
          clk_taken   = w.enc_clock;
          since_taken = '0;
        end else begin
          since_taken = elapsed;
        end
        clk_level = w.enc_clock;

        // running wait counts down first, its last tick's key decides
        if (key_wait) begin
          key_wait_left = key_wait_left - 10'd1;
          if (key_wait_left == 10'd0) begin
            if (!w.key_level) begin
              flag_now = ~flag_now;
              key_toggles++;
            end
            key_wait = 1'b0;
          end
        end
        // a press edge only starts a wait when none is running
        if (!key_wait && key_prev && !w.key_level) begin
          key_wait      = 1'b1;
          key_wait_left = (cfg_debounce == 10'd0) ? 10'd1 : cfg_debounce;
        end
        key_prev = w.key_level;
      end
      OP_SET:  count_now = w.load_value;
      OP_FLAG: flag_now = ~flag_now;
      default: ;
    endcase
    r.position       = count_now;
    r.display_nibble = count_now[3:0];
    r.cw_lamp        = cw_now;
    r.ccw_lamp       = ccw_now;
    r.flag_lamp      = flag_now;
    r.step_taken     = step;
    return r;
  endfunction

  task automatic note_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    if (mismatches < 40)
      $display("tb: %s at %0t: got %h, expected %h", what, $time, got, want);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // handshake monitor: sampled right at the edge, before any new drive lands
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : scoreboard
    rep_out_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (predicted_panel.size() == 0) begin
          note_mismatch("result with nothing pending, position", out_data.position, '0);
        end else begin
          want = predicted_panel.pop_front();
          if (out_data.position !== want.position)
            note_mismatch("position", out_data.position, want.position);
          if (out_data.display_nibble !== want.display_nibble)
            note_mismatch("display_nibble", out_data.display_nibble, want.display_nibble);
          if (out_data.cw_lamp !== want.cw_lamp)
            note_mismatch("cw_lamp", out_data.cw_lamp, want.cw_lamp);
          if (out_data.ccw_lamp !== want.ccw_lamp)
            note_mismatch("ccw_lamp", out_data.ccw_lamp, want.ccw_lamp);
          if (out_data.flag_lamp !== want.flag_lamp)
            note_mismatch("flag_lamp", out_data.flag_lamp, want.flag_lamp);
          if (out_data.step_taken !== want.step_taken)
            note_mismatch("step_taken", out_data.step_taken, want.step_taken);
        end
      end
      // register writes only happen while idle, so order against words is safe
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_LOCKOUT:  cfg_lockout  = cfg_data[7:0];
          CFG_DEBOUNCE: cfg_debounce = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        words_taken++;
        predicted_panel.push_back(panel_advance(in_data));
      end
    end
  end

  // result side back-pressure in random bursts while pacing_on is set
  always begin : result_pacing
    int unsigned hold;
    @(posedge clk);
    if (pacing_on && $urandom_range(0, 7) == 0) begin
      hold = $urandom_range(1, 11);
      out_ready <= 1'b0;
      repeat (hold) @(posedge clk);
    end
    out_ready <= 1'b1;
  end

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // sends one word; returns in the time step of the edge that took it
  task automatic send_op(input logic [1:0] op, input logic c, input logic d,
                         input logic k, input logic [31:0] count);
    rep_in_t     w;
    int unsigned gap;
    w.op         = op;
    w.enc_clock  = c;
    w.enc_data   = d;
    w.key_level  = k;
    w.load_value = count;
    if (pacing_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 11);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // stop sending, let every pending result drain, then a short quiet spell
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (predicted_panel.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset settings: ops, lockout window, fall after an ignored rise, wraps
  task automatic test_directed_ops();
    send_op(OP_SPARE, 1'b0, 1'b1, 1'b0, 32'hFFFF_FFFF); // no-op shows reset state
    send_op(OP_FLAG, 1'b1, 1'b1, 1'b0, 32'h0);
    send_op(OP_SET, 1'b0, 1'b0, 1'b0, 32'h8000_0000);
    send_op(OP_TICK, 1'b0, 1'b0, 1'b1, $urandom);       // down, wraps to max
    send_op(OP_TICK, 1'b1, 1'b0, 1'b1, $urandom);       // rise inside lockout
    send_op(OP_TICK, 1'b1, 1'b0, 1'b1, $urandom);
    send_op(OP_TICK, 1'b1, 1'b0, 1'b1, $urandom);
    send_op(OP_TICK, 1'b0, 1'b1, 1'b1, $urandom);       // accepted, no step
    send_op(OP_TICK, 1'b0, 1'b1, 1'b1, $urandom);
    send_op(OP_TICK, 1'b0, 1'b1, 1'b1, $urandom);
    send_op(OP_TICK, 1'b1, 1'b1, 1'b1, $urandom);       // accepted rise
    send_op(OP_TICK, 1'b1, 1'b0, 1'b1, $urandom);
    send_op(OP_TICK, 1'b1, 1'b0, 1'b1, $urandom);
    send_op(OP_TICK, 1'b0, 1'b1, 1'b1, $urandom);       // up, wraps to min
    send_op(OP_SET, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF);
    send_op(OP_SET, 1'b1, 1'b0, 1'b1, 32'h0000_0000);
    settle();
  endtask

  // short key wait: confirm, early release, restart on the ending tick
  task automatic test_key_debounce();
    write_reg(CFG_DEBOUNCE, 10'd2);
    send_op(OP_TICK, 1'b1, 1'b0, 1'b1, $urandom);
    send_op(OP_TICK, 1'b1, 1'b0, 1'b0, $urandom);       // press starts wait
    send_op(OP_TICK, 1'b1, 1'b1, 1'b1, $urandom);       // bounce, ignored
    send_op(OP_TICK, 1'b1, 1'b0, 1'b0, $urandom);       // confirm and restart
    send_op(OP_FLAG, 1'b0, 1'b0, 1'b1, $urandom);       // does not count down
    send_op(OP_SET, 1'b0, 1'b1, 1'b1, 32'h0000_000F);
    send_op(OP_TICK, 1'b1, 1'b0, 1'b0, $urandom);
    send_op(OP_TICK, 1'b1, 1'b0, 1'b1, $urandom);       // released, no toggle
    send_op(OP_TICK, 1'b1, 1'b1, 1'b0, $urandom);
    send_op(OP_TICK, 1'b1, 1'b1, 1'b0, $urandom);
    send_op(OP_TICK, 1'b1, 1'b1, 1'b0, $urandom);       // held, toggles
    settle();
  endtask

  // lockout at max never accepts, zero key wait acts as one, lockout zero
  task automatic test_lockout_extremes();
    int unsigned i;
    write_reg(CFG_LOCKOUT, 10'd255);
    write_reg(CFG_DEBOUNCE, 10'd0);
    send_op(OP_TICK, 1'b0, 1'b1, 1'b1, $urandom);
    send_op(OP_TICK, 1'b1, 1'b0, 1'b0, $urandom);
    send_op(OP_TICK, 1'b0, 1'b0, 1'b0, $urandom);
    send_op(OP_TICK, 1'b1, 1'b1, 1'b1, $urandom);
    settle();
    write_reg(CFG_LOCKOUT, 10'd0);
    write_reg(CFG_DEBOUNCE, 10'd1);
    // clock changes every tick, every change accepted
    for (i = 0; i < 6; i++)
      send_op(OP_TICK, i[0], i[1], 1'b1, $urandom);
    settle();
  endtask

  // longest key wait while the encoder spins at full rate
  task automatic test_long_key_wait();
    int unsigned i;
    write_reg(CFG_LOCKOUT, 10'd0);
    write_reg(CFG_DEBOUNCE, 10'd1023);
    send_op(OP_TICK, 1'b1, 1'b1, 1'b1, $urandom);
    send_op(OP_TICK, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b0,
            $urandom);
    // a release and re-press midway falls inside the wait and is ignored
    for (i = 0; i < 1023; i++)
      send_op(OP_TICK, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
              (i == 500), $urandom);
    send_op(OP_TICK, 1'b1, 1'b1, 1'b1, $urandom);
    settle();
  endtask

  // mostly clean detent motion and key presses, with loads and noise mixed in
  task automatic test_random_phase(input int unsigned n_words, input logic [7:0] lockout,
                                   input logic [9:0] debounce);
    int unsigned lock_c, deb_c, clk_hold, key_hold, counted, pick;
    logic        c, d, k;
    logic [1:0]  junk;
    logic [31:0] count;
    junk = 2'($urandom);
    // upper data bits are don't-care for the lockout register
    write_reg(CFG_LOCKOUT, {junk, lockout});
    write_reg(CFG_DEBOUNCE, debounce);
    lock_c   = (lockout > 10) ? 10 : lockout;
    deb_c    = (debounce > 60) ? 60 : ((debounce == 0) ? 1 : debounce);
    c        = 1'b1;
    d        = 1'b1;
    k        = 1'b1;
    clk_hold = 1;
    key_hold = 1;
    counted  = 0;
    while (counted < n_words) begin
      pick  = $urandom_range(0, 99);
      count = $urandom;
      if (pick < 88) begin
        clk_hold = clk_hold - 1;
        if (clk_hold == 0) begin
          c = ~c;
          // direction runs for a while, flips now and then on the fall
          if (!c && $urandom_range(0, 4) == 0)
            d = ~d;
          // most dwell times clear a lockout of up to 10, some fall inside it
          if ($urandom_range(0, 3) != 0)
            clk_hold = $urandom_range(lock_c + 1, lock_c + 4);
          else
            clk_hold = $urandom_range(1, lock_c + 1);
        end
        key_hold = key_hold - 1;
        if (key_hold == 0) begin
          k = ~k;
          if (k)
            key_hold = $urandom_range(1, 8);
          else if ($urandom_range(0, 9) < 7)
            key_hold = $urandom_range(deb_c, deb_c + 4);
          else
            key_hold = $urandom_range(1, 2);
        end
        send_op(OP_TICK, c, d, k, count);
        counted++;
      end else if (pick < 92) begin
        case ($urandom_range(0, 4))
          0: count = 32'h7FFF_FFFF;
          1: count = 32'h8000_0000;
          2: count = 32'hFFFF_FFFF;
          default: ;
        endcase
        send_op(OP_SET, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)), count);
        counted++;
      end else if (pick < 95) begin
        send_op(OP_FLAG, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)), count);
        counted++;
      end else if (pick < 97) begin
        send_op(OP_SPARE, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)), count);
      end else begin
        // pin noise outside the clean pattern
        send_op(OP_TICK, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)), count);
        counted++;
      end
    end
    settle();
  endtask

  // ---------------------------------------------------------------------------
  // run
  // ---------------------------------------------------------------------------
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb: cycle limit reached");
    $display("tb NOT OK");
    $finish;
  end

  initial begin : run
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_ops();
    test_key_debounce();
    test_lockout_extremes();
    test_long_key_wait();

    test_random_phase(80, 8'd0, 10'd1);
    test_random_phase(80, 8'd1, 10'd0);
    // a write to the unused index must leave both registers alone
    write_reg(CFG_SPARE, 10'($urandom));
    test_random_phase(80, 8'($urandom_range(0, 6)), 10'($urandom_range(1, 12)));
    test_random_phase(50, 8'd255, 10'($urandom_range(1, 8)));
    test_random_phase(80, 8'($urandom_range(0, 10)), 10'($urandom_range(20, 60)));
    // last stretch at full rate on both sides
    pacing_on = 1'b0;
    test_random_phase(80, 8'($urandom_range(0, 4)), 10'($urandom_range(1, 8)));

    $display("tb: %0d words taken, %0d results checked, %0d up and %0d down steps",
             words_taken, results_seen, up_steps, down_steps);
    $display("tb: %0d key-confirmed flag toggles, lockout 0..255, key wait 0..1023, %0d bad",
             key_toggles, mismatches);
    if (mismatches == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
